FILE: hdl/ascii_decimal_to_fixed_assert.svh
// Assertion macros shared by the checker of the decimal text to fixed-point converter.
`ifndef ASCII_DECIMAL_TO_FIXED_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ADF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ADF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/adf_pkg.sv
// Shared constants, types and tables of the decimal text to fixed-point converter.
package adf_pkg;

  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 64;
  localparam int FRAC_ACC_W = 30;
  localparam int CNT_W      = 4;

  localparam int INT_BITS_DEF        = 32;
  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

  // Powers of ten for the number of fraction digits kept; counts above nine clamp.
  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [FRAC_ACC_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/adf_digit_parse.sv
// Byte-by-byte parser that accumulates sign, integer digits and fraction digits.
module adf_digit_parse #(
  parameter int INT_BITS        = adf_pkg::INT_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = adf_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          clear,
  input  logic [adf_pkg::CHAR_W-1:0]    char_code,
  output logic [INT_BITS-1:0]           int_acc,
  output logic [adf_pkg::FRAC_ACC_W-1:0] frac_acc,
  output logic [adf_pkg::CNT_W-1:0]     frac_cnt,
  output logic                          negative,
  output logic                          saturated
);

  localparam int NV_W = INT_BITS + 4;

  typedef enum logic [3:0] {
    PH_WS   = 4'b0001,
    PH_INT  = 4'b0010,
    PH_FRAC = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  localparam logic [NV_W-1:0] INT_LIMIT = NV_W'({1'b1, {(INT_BITS-1){1'b0}}});

  phase_t                          phase, phase_next;
  logic [INT_BITS-1:0]             int_acc_next;
  logic [adf_pkg::FRAC_ACC_W-1:0]  frac_acc_next;
  logic [adf_pkg::CNT_W-1:0]       frac_cnt_next;
  logic                            negative_next;
  logic                            saturated_next;

  logic                            is_space;
  logic                            is_decimal;
  logic [3:0]                      digit;
  logic [NV_W-1:0]                 int_prod;
  logic [adf_pkg::FRAC_ACC_W-1:0]  frac_prod;

  assign is_space = (char_code == adf_pkg::CH_SPACE) ||
                    ((char_code >= adf_pkg::CH_TAB) && (char_code <= adf_pkg::CH_CR));
  assign is_decimal = (char_code >= adf_pkg::CH_ZERO) && (char_code <= adf_pkg::CH_NINE);
  assign digit    = 4'(char_code - adf_pkg::CH_ZERO);

  // acc * 10 + d as two shifts and two adds.
  assign int_prod = NV_W'({int_acc, 3'b000}) + NV_W'({int_acc, 1'b0}) + NV_W'(digit);
  assign frac_prod = {frac_acc[adf_pkg::FRAC_ACC_W-4:0], 3'b000} +
                     {frac_acc[adf_pkg::FRAC_ACC_W-2:0], 1'b0} +
                     adf_pkg::FRAC_ACC_W'(digit);

  always_comb begin
    logic int_digit;
    logic frac_digit;
    int_digit      = 1'b0;
    frac_digit     = 1'b0;
    phase_next     = phase;
    negative_next  = negative;
    int_acc_next   = int_acc;
    frac_acc_next  = frac_acc;
    frac_cnt_next  = frac_cnt;
    saturated_next = saturated;

    if (take) begin
      case (phase)
        PH_WS: begin
          if (is_space) begin
            phase_next = PH_WS;
          end else if ((char_code == adf_pkg::CH_PLUS) || (char_code == adf_pkg::CH_MINUS)) begin
            negative_next = (char_code == adf_pkg::CH_MINUS);
            phase_next    = PH_INT;
          end else if (is_decimal) begin
            int_digit  = 1'b1;
            phase_next = PH_INT;
          end else if (char_code == adf_pkg::CH_DOT) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_INT: begin
          if (is_decimal) begin
            int_digit = 1'b1;
          end else if (char_code == adf_pkg::CH_DOT) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_decimal) begin
            frac_digit = 1'b1;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    // Once the integer part has passed its limit and saturated, further digits change nothing.
    if (int_digit && !saturated) begin
      if (int_prod > INT_LIMIT) begin
        int_acc_next   = INT_LIMIT[INT_BITS-1:0];
        saturated_next = 1'b1;
      end else begin
        int_acc_next = int_prod[INT_BITS-1:0];
      end
    end

    if (frac_digit && (frac_cnt < adf_pkg::CNT_W'(MAX_FRAC_DIGITS))) begin
      frac_acc_next = frac_prod;
      frac_cnt_next = frac_cnt + adf_pkg::CNT_W'(1);
    end

    if (clear) begin
      phase_next     = PH_WS;
      negative_next  = 1'b0;
      int_acc_next   = '0;
      frac_acc_next  = '0;
      frac_cnt_next  = '0;
      saturated_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WS;
      negative  <= 1'b0;
      int_acc   <= '0;
      frac_acc  <= '0;
      frac_cnt  <= '0;
      saturated <= 1'b0;
    end else begin
      phase     <= phase_next;
      negative  <= negative_next;
      int_acc   <= int_acc_next;
      frac_acc  <= frac_acc_next;
      frac_cnt  <= frac_cnt_next;
      saturated <= saturated_next;
    end
  end

endmodule

FILE: hdl/adf_frac_div.sv
// Restoring divider: one shift, compare and subtract per cycle, one quotient bit each.
module adf_frac_div #(
  parameter int FRAC_BITS = adf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  adf_pkg::div_ctrl_t             ctrl,
  input  logic [adf_pkg::FRAC_ACC_W-1:0] dividend,
  input  logic [adf_pkg::CNT_W-1:0]      digit_cnt,
  output adf_pkg::div_stat_t             stat,
  output logic [FRAC_BITS-1:0]           quotient
);

  localparam int STEP_W = $clog2(FRAC_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_BITS - 1);

  logic                           busy;
  logic                           done;
  logic [STEP_W-1:0]              step;
  logic [adf_pkg::FRAC_ACC_W-1:0] rem;
  logic [adf_pkg::FRAC_ACC_W-1:0] divisor;
  logic [adf_pkg::FRAC_ACC_W:0]   shifted;
  logic [adf_pkg::FRAC_ACC_W:0]   diff;
  logic                           fits;

  // The remainder stays below the divisor, so one extra bit holds its double.
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = !diff[adf_pkg::FRAC_ACC_W];

  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= dividend;
      divisor  <= adf_pkg::pow10(digit_cnt);
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[adf_pkg::FRAC_ACC_W-1:0] : shifted[adf_pkg::FRAC_ACC_W-1:0];
      quotient <= {quotient[FRAC_BITS-2:0], fits};
    end
  end

endmodule

FILE: hdl/ascii_decimal_to_fixed.sv
// Decimal text to signed fixed-point converter: one ASCII byte per word, one result per string.
// A byte that is not the last of its string leaves the block in S_IDLE, ready for the next byte.
// After the last byte the block loads the divider, lets it produce the quotient bits, waits for
// its done flag and writes the output register (Q31.32 at the default sizes).
// The input stays closed until the result is written, longer while the previous result word
// waits. Synchronous active-high reset returns parser, divider and output to idle.
module ascii_decimal_to_fixed #(
  parameter int INT_BITS        = adf_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS       = adf_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = adf_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [adf_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_code
  input  logic                          s_tlast,   // end_of_string
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [adf_pkg::VALUE_W-1:0]   m_tdata,   // [63:0] value
  output logic [0:0]                    m_tuser    // [0] overflow
);

  localparam int MAG_W = INT_BITS + FRAC_BITS;

  localparam logic [MAG_W-1:0] MAG_HALF = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_MAX  = {1'b0, {(MAG_W-1){1'b1}}};

  // Sequencer: bytes are taken only in S_IDLE; the end of a string walks through
  // loading the divider, waiting for it, and writing the output register.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_DIV   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t state, state_next;

  logic                           in_take;
  logic                           out_free;
  logic                           out_write;

  logic [INT_BITS-1:0]            int_acc;
  logic [adf_pkg::FRAC_ACC_W-1:0] frac_acc;
  logic [adf_pkg::CNT_W-1:0]      frac_cnt;
  logic                           negative;
  logic                           saturated;

  adf_pkg::div_ctrl_t             div_ctrl;
  adf_pkg::div_stat_t             div_stat;
  logic [FRAC_BITS-1:0]           frac_q;

  logic [MAG_W-1:0]               mag;
  logic                           too_big;
  logic [MAG_W-1:0]               mag_clamped;
  logic [adf_pkg::VALUE_W-1:0]    mag_wide;
  logic [adf_pkg::VALUE_W-1:0]    value_next;

  assign s_tready  = (state == S_IDLE);
  assign in_take   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign out_write = (state == S_FINAL) && out_free;

  assign div_ctrl.start = (state == S_LOAD);

  adf_digit_parse #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (in_take),
    .clear     (out_write),
    .char_code (s_tdata),
    .int_acc   (int_acc),
    .frac_acc  (frac_acc),
    .frac_cnt  (frac_cnt),
    .negative  (negative),
    .saturated (saturated)
  );

  adf_frac_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (frac_acc),
    .digit_cnt (frac_cnt),
    .stat      (div_stat),
    .quotient  (frac_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_take && s_tlast) state_next = S_LOAD;
      S_LOAD:  state_next = S_DIV;
      S_DIV:   if (div_stat.done) state_next = S_FINAL;
      S_FINAL: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The fraction quotient is always below one, so the magnitude is a plain concatenation.
  // The integer part never exceeds 2^(INT_BITS-1): its top bit set means it sits exactly
  // at that limit, which overflows a positive result, and a negative one only with a
  // nonzero fraction or when digits were dropped.
  assign mag = {int_acc, frac_q};

  always_comb begin
    if (negative) begin
      too_big = saturated || (int_acc[INT_BITS-1] && (frac_q != '0));
    end else begin
      too_big = saturated || int_acc[INT_BITS-1];
    end
    if (too_big) begin
      mag_clamped = negative ? MAG_HALF : MAG_MAX;
    end else begin
      mag_clamped = mag;
    end
    mag_wide   = adf_pkg::VALUE_W'(mag_clamped);
    value_next = negative ? (adf_pkg::VALUE_W'(0) - mag_wide) : mag_wide;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_write) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The output word is held until taken; a new string may be parsed meanwhile.
  always_ff @(posedge clk) begin
    if (out_write) begin
      m_tdata    <= value_next;
      m_tuser[0] <= too_big;
    end
  end

endmodule

FILE: hdl/adf_checker.sv
// Port-level checker of the decimal text to fixed-point converter, with its bind.
`include "ascii_decimal_to_fixed_assert.svh"

module adf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [adf_pkg::VALUE_W-1:0] m_tdata,
  input logic [0:0]                  m_tuser
);

  logic                        end_taken;
  logic                        out_stall;
  logic [adf_pkg::VALUE_W:0]   out_word;

  assign end_taken = s_tvalid && s_tready && s_tlast;
  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tuser, m_tdata};

  // A stalled output word stays offered.
  `ADF_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid, "output word dropped while stalled")

  // A stalled output word keeps its value and flag.
  `ADF_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_word), "stalled output word changed")

  // The last byte of a string starts the division, so input is closed right after it.
  `ADF_ASSERT_NEXT(a_busy_after_end, end_taken, !s_tready, "input open right after last byte")

  // A new result only appears out of the busy phase.
  `ADF_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), !$past(s_tready), "result while idle")

endmodule

bind ascii_decimal_to_fixed adf_checker u_adf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: dv/tb_ascii_decimal_to_fixed.sv
// Self-checking testbench for the decimal text to Q31.32 fixed-point converter.
module tb_ascii_decimal_to_fixed;
  timeunit 1ns;
  timeprecision 1ps;

  // The block runs with its default sizes: Q31.32 and nine kept fraction digits.
  localparam int FRAC_W      = adf_pkg::FRAC_BITS_DEF;
  localparam int INT_W       = adf_pkg::INT_BITS_DEF;
  localparam int KEEP_DIGITS = adf_pkg::MAX_FRAC_DIGITS_DEF;

  // Extra drain time at the end, to cover the tail of a run.
  localparam int DRAIN_CYCLES = 2 * (FRAC_W + 3);
  localparam int RANDOM_WORDS = 1200;
  localparam int LONG_HOLD    = 400;

  localparam logic [63:0] INT_LIMIT  = 64'd1 << (INT_W - 1);
  localparam logic [63:0] HALF_RANGE = 64'd1 << (INT_W + FRAC_W - 1);

  typedef enum logic [3:0] {
    PH_LEADING_WS = 4'b0001,
    PH_INTEGER    = 4'b0010,
    PH_FRACTION   = 4'b0100,
    PH_DONE       = 4'b1000
  } text_phase_t;

  typedef struct {
    logic [adf_pkg::VALUE_W-1:0] value;
    logic                        overflow;
  } fixed_result_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [adf_pkg::CHAR_W-1:0]  s_tdata;    // [7:0] char_code
  logic                        s_tlast;    // end_of_string
  logic                        m_tvalid;
  logic                        m_tready;
  logic [adf_pkg::VALUE_W-1:0] m_tdata;    // [63:0] value
  logic [0:0]                  m_tuser;    // [0] overflow

  ascii_decimal_to_fixed i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-wide bookkeeping. The receiver picks up hold_request and clears it; the test
  // sequence only ever raises it. no_idle turns off the random gaps on both sides.
  int  error_count  = 0;
  int  hold_request = 0;
  bit  no_idle      = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Parser model. It tracks the same phases as the block and forms the fixed-point value
  // when the last byte of a string is accepted. Expected values wait in arrival order.
  // ---------------------------------------------------------------------------------------
  text_phase_t                    phase         = PH_LEADING_WS;
  logic                           neg_sign      = 1'b0;
  logic [31:0]                    int_part      = '0;
  logic [adf_pkg::FRAC_ACC_W-1:0] frac_digits   = '0;
  logic [adf_pkg::CNT_W-1:0]      frac_count    = '0;
  logic                           int_saturated = 1'b0;
  fixed_result_t                  expected_results[$];

  function automatic bit is_blank(input logic [adf_pkg::CHAR_W-1:0] c);
    return c == adf_pkg::CH_SPACE || (c >= adf_pkg::CH_TAB && c <= adf_pkg::CH_CR);
  endfunction

  function automatic bit is_numeral(input logic [adf_pkg::CHAR_W-1:0] c);
    return c >= adf_pkg::CH_ZERO && c <= adf_pkg::CH_NINE;
  endfunction

  function automatic void clear_number();
    phase         = PH_LEADING_WS;
    neg_sign      = 1'b0;
    int_part      = '0;
    frac_digits   = '0;
    frac_count    = '0;
    int_saturated = 1'b0;
  endfunction

  // Once the integer part passes 2^(INT_BITS-1) it sticks there and ignores later digits.
  function automatic void push_int_digit(input logic [adf_pkg::CHAR_W-1:0] c);
    logic [63:0] grown;
    if (int_saturated) return;
    grown = {32'd0, int_part} * 64'd10 + 64'(c - adf_pkg::CH_ZERO);
    if (grown > INT_LIMIT) begin
      int_part      = INT_LIMIT[31:0];
      int_saturated = 1'b1;
    end else begin
      int_part = grown[31:0];
    end
  endfunction

  // Fraction digits beyond the kept count are swallowed without effect.
  function automatic void push_frac_digit(input logic [adf_pkg::CHAR_W-1:0] c);
    if (frac_count < KEEP_DIGITS) begin
      frac_digits = frac_digits * 30'd10 + 30'(c - adf_pkg::CH_ZERO);
      frac_count  = frac_count + 1'b1;
    end
  endfunction

  function automatic void predict_word(input logic [adf_pkg::CHAR_W-1:0] c, input logic last);
    logic [63:0]   scale;
    logic [63:0]   frac_part;
    logic [63:0]   mag;
    logic [63:0]   ceiling;
    fixed_result_t r;
    case (phase)
      PH_LEADING_WS: begin
        if (is_blank(c)) begin
          phase = PH_LEADING_WS;
        end else if (c == adf_pkg::CH_PLUS || c == adf_pkg::CH_MINUS) begin
          neg_sign = (c == adf_pkg::CH_MINUS);
          phase    = PH_INTEGER;
        end else if (is_numeral(c)) begin
          push_int_digit(c);
          phase = PH_INTEGER;
        end else if (c == adf_pkg::CH_DOT) begin
          phase = PH_FRACTION;
        end else begin
          phase = PH_DONE;
        end
      end
      PH_INTEGER: begin
        if (is_numeral(c)) push_int_digit(c);
        else if (c == adf_pkg::CH_DOT) phase = PH_FRACTION;
        else phase = PH_DONE;
      end
      PH_FRACTION: begin
        if (is_numeral(c)) push_frac_digit(c);
        else phase = PH_DONE;
      end
      default: phase = PH_DONE;
    endcase
    if (!last) return;

    // Fraction bits are floor(digits * 2^FRAC_BITS / 10^count); truncation means the
    // result always rounds toward zero, whatever the sign.
    scale = 64'd1;
    for (int i = 0; i < frac_count; i++) scale = scale * 64'd10;
    frac_part = ({34'd0, frac_digits} << FRAC_W) / scale;
    mag       = ({32'd0, int_part} << FRAC_W) + frac_part;

    // The negative side reaches one step further than the positive side.
    ceiling    = neg_sign ? HALF_RANGE : HALF_RANGE - 64'd1;
    r.overflow = int_saturated;
    if (int_saturated || mag > ceiling) begin
      mag        = ceiling;
      r.overflow = 1'b1;
    end
    r.value = neg_sign ? -mag : mag;
    expected_results.push_back(r);
    clear_number();
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side. m_tready changes on the falling edge. A long hold, when requested, is
  // counted down here so that the sender keeps pushing bytes while results back up.
  // ---------------------------------------------------------------------------------------
  initial begin : result_receiver
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  // Every accepted result word is checked against the oldest pending string value.
  always @(posedge clk) begin : result_checker
    fixed_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result word with no string pending: value=%h overflow=%b", m_tdata, m_tuser[0]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.value) begin
          $error("Mismatch on value: expected %h, got %h", want.value, m_tdata);
          error_count++;
        end
        if (m_tuser[0] !== want.overflow) begin
          $error("Mismatch on overflow: expected %b, got %b", want.overflow, m_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Byte side. Each call starts and ends on a falling edge. s_tvalid stays high from one
  // word to the next unless a gap is drawn, so it is never dropped and raised in one step.
  // ---------------------------------------------------------------------------------------
  task automatic send_word(input logic [adf_pkg::CHAR_W-1:0] c, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= c;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_word(c, last);
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  // Random text is built here and then sent as one string.
  logic [adf_pkg::CHAR_W-1:0] pending_text[$];

  function automatic logic [adf_pkg::CHAR_W-1:0] random_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? adf_pkg::CH_SPACE : 8'(adf_pkg::CH_TAB + k);
  endfunction

  function automatic logic [adf_pkg::CHAR_W-1:0] random_numeral();
    return 8'(adf_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic void append_decimal(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
  endfunction

  // Mostly well-formed numbers with random content, including integer parts around the
  // saturation point and fractions longer than the kept digits; the rest is broken
  // sequences drawn from the number alphabet and plain byte noise.
  function automatic void compose_text();
    int unsigned kind;
    int unsigned roll;
    int unsigned n;
    pending_text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) pending_text.push_back(random_blank());
      end
      case ($urandom_range(0, 5))
        0:       pending_text.push_back(adf_pkg::CH_MINUS);
        1:       pending_text.push_back(adf_pkg::CH_PLUS);
        default: ;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        // No integer digits at all.
      end else if (roll < 55) begin
        append_decimal($urandom_range(0, 999));
      end else if (roll < 75) begin
        append_decimal($urandom);
      end else if (roll < 90) begin
        append_decimal(32'd2147483638 + $urandom_range(0, 20));
      end else begin
        repeat ($urandom_range(11, 14)) pending_text.push_back(random_numeral());
      end
      if ($urandom_range(0, 1) == 1) begin
        pending_text.push_back(adf_pkg::CH_DOT);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 9);
        repeat (n) pending_text.push_back(random_numeral());
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) pending_text.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 4))
          0:       pending_text.push_back(adf_pkg::CH_MINUS);
          1:       pending_text.push_back(adf_pkg::CH_PLUS);
          2:       pending_text.push_back(adf_pkg::CH_DOT);
          3:       pending_text.push_back(random_blank());
          default: pending_text.push_back(random_numeral());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 6)) pending_text.push_back(8'($urandom_range(0, 255)));
    end
    if (pending_text.size() == 0) pending_text.push_back(random_numeral());
  endfunction

  task automatic send_random_string(inout int words_sent);
    compose_text();
    foreach (pending_text[i]) send_word(pending_text[i], i == pending_text.size() - 1);
    words_sent += pending_text.size();
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // A NUL and an all-ones byte alone end the parse with no digits, giving zero; a letter
  // after a digit stops the parse and the rest of the string is ignored.
  task automatic test_odd_bytes();
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_string("7x9");
  endtask

  // All six blank bytes are skipped up front; a second sign ends the parse, and so does a
  // blank after a digit.
  task automatic test_blanks_and_signs();
    send_string("\011\012\013\014\015 -7");
    send_string("+-5");
    send_string("4 2");
    send_string("-.5");
  endtask

  // Ten fraction digits: the last one is consumed and dropped.
  task automatic test_fraction_limit();
    send_string(".9999999999");
  endtask

  // 2^31 fits the integer accumulator but not the positive range; its negative twin is
  // exactly the most negative value; an eleven-digit integer saturates.
  task automatic test_saturation();
    send_string("2147483648");
    send_string("-2147483648");
    send_string("99999999999");
  endtask

  task automatic test_random_strings();
    int words_sent;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) send_random_string(words_sent);
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    int words_sent;
    words_sent = 0;
    no_idle = 1'b1;
    repeat (12) send_random_string(words_sent);
    no_idle = 1'b0;
  endtask

  // The receiver stops for a long time while bytes keep coming, so that the held result
  // fills the block and it stops taking input until the receiver resumes.
  task automatic test_output_stall();
    int words_sent;
    words_sent   = 0;
    hold_request = LONG_HOLD;
    repeat (15) send_random_string(words_sent);
  endtask

  initial begin : test_sequence
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_odd_bytes();
    test_blanks_and_signs();
    test_fraction_limit();
    test_saturation();
    test_random_strings();
    test_back_to_back();
    test_output_stall();

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // The whole run needs well under a tenth of this.
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/adf_pkg.sv
hdl/adf_digit_parse.sv
hdl/adf_frac_div.sv
hdl/ascii_decimal_to_fixed.sv
hdl/adf_checker.sv
dv/tb_ascii_decimal_to_fixed.sv
